// ===== design/raised_cosine_window_apply_defines.svh =====
// assertion macros for the raised cosine window block
// used by the top level only, no other dependencies
`ifndef RAISED_COSINE_WINDOW_APPLY_DEFINES_SVH
`define RAISED_COSINE_WINDOW_APPLY_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define RCWA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define RCWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rcwa_pkg.sv =====
// shared types, constants and the quarter-wave cosine table
// for the raised cosine window block; no dependencies
package rcwa_pkg;

   // sizing
   localparam int SAMPLE_BITS     = 16;
   localparam int POSITION_BITS   = 16;
   localparam int COS_TABLE_DEPTH = 256;

   // fixed field widths
   localparam int LENGTH_BITS    = 16;
   localparam int PHASE_BITS     = 24;
   localparam int COEF_BITS      = 16;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int COS_VALUE_BITS = 16;   // table entries, 0 .. 32768
   localparam int WEIGHT_BITS    = 16;   // Q1.15 weight, 0 .. 32768
   localparam int COS_IDX_BITS   = $clog2(COS_TABLE_DEPTH) + 1;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH     = 2'd0,
      CSR_PHASE_STEP        = 2'd1,
      CSR_FLOOR_COEFFICIENT = 2'd2
   } csr_index_type;

   // controller states
   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_WEIGHT,
      CTRL_PRODUCT
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_input;    // request taken: capture sample, cosine, advance counters
      logic load_weight;   // weight register takes the raised cosine weight
      logic load_output;   // result register takes the windowed sample
   } ctrl_cmd_type;

   typedef logic [COS_VALUE_BITS-1:0] cos_table_type [COS_TABLE_DEPTH+1];

   // one entry: Taylor series of cos in Q2.30, Horner form, rounded to Q1.15
   function automatic logic [COS_VALUE_BITS-1:0] cos_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] tp;
      logic [63:0] prod;
      logic [63:0] quot;
      longint      t;
      x = (64'(k) * 64'd1686629713 + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t = 64'sd1073741824;
      for (int d = 0; d < 7; d++) begin
         tp = (t < 0) ? 64'd0 : 64'(t);
         prod = (x2 * tp) >> 30;
         case (d)
            0: quot = prod / 64'd182;
            1: quot = prod / 64'd132;
            2: quot = prod / 64'd90;
            3: quot = prod / 64'd56;
            4: quot = prod / 64'd30;
            5: quot = prod / 64'd12;
            default: quot = prod / 64'd2;
         endcase
         t = 64'sd1073741824 - longint'(quot);
      end
      if (t < 0) t = 0;
      if (t > 64'sd1073741824) t = 64'sd1073741824;
      return COS_VALUE_BITS'((64'(t) + 64'd16384) >> 15);
   endfunction

   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
         tbl[k] = cos_entry(k);
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

// ===== design/rcwa_controller.sv =====
// sequencer for the raised cosine window block: intake, weight, product
// depends on rcwa_pkg
module rcwa_controller
   import rcwa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      slot_free       = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in       = CTRL_WEIGHT;
            end
         end
         CTRL_WEIGHT: begin
            cmd.load_weight = 1'b1;
            state_in        = CTRL_PRODUCT;
         end
         CTRL_PRODUCT: begin
            // wait here until the result register can take a new value
            if (slot_free) begin
               cmd.load_output = 1'b1;
               state_in        = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
      if (cmd.load_output) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/rcwa_datapath.sv =====
// registers, counters, cosine lookup, weight and product arithmetic
// depends on rcwa_pkg
module rcwa_datapath
   import rcwa_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  ctrl_cmd_type                    cmd,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample,
   input  logic                            csr_write_enable,
   input  logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [CSR_DATA_BITS-1:0] csr_write_data,
   output logic signed [SAMPLE_BITS-1:0]   rsp_windowed_sample,
   output logic                            rsp_window_end
);

   localparam int CMP_BITS   = ((LENGTH_BITS > POSITION_BITS) ? LENGTH_BITS : POSITION_BITS) + 1;
   localparam int SCALE_BITS = (PHASE_BITS - 2) + COS_IDX_BITS;
   localparam int PROD_BITS  = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int Y_BITS     = PROD_BITS - 15;

   // configuration
   logic [LENGTH_BITS-1:0] window_length_ff;
   logic [PHASE_BITS-1:0]  phase_step_ff;
   logic [COEF_BITS-1:0]   floor_coef_ff;

   // counters
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;

   // pipeline of one item
   logic signed [SAMPLE_BITS-1:0]  sample_ff;
   logic signed [COS_VALUE_BITS:0] cos_ff, cos_in;
   logic                           last_ff, last_in;
   logic [WEIGHT_BITS-1:0]         weight_ff, weight_in;
   logic signed [SAMPLE_BITS-1:0]  windowed_ff, windowed_in;
   logic                           window_end_ff;

   // intake signals
   logic [1:0]                quadrant;
   logic [SCALE_BITS-1:0]     scaled;
   logic [COS_IDX_BITS-1:0]   idx_raw, idx, table_addr;
   logic [COS_VALUE_BITS-1:0] table_value;
   logic [CMP_BITS-1:0]       pos_next, len_eff;

   // weight signals
   logic [COEF_BITS-1:0]          coef_sat;
   logic [WEIGHT_BITS-1:0]        one_minus_a;
   logic signed [COS_VALUE_BITS+1:0] one_minus_c_wide;
   logic [COS_VALUE_BITS:0]       one_minus_c;
   logic [WEIGHT_BITS+COS_VALUE_BITS+1:0] span_prod;

   // product signals
   logic signed [PROD_BITS-1:0] product;
   logic signed [PROD_BITS-1:0] rounded;
   logic signed [Y_BITS-1:0]    y;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= LENGTH_BITS'(1024);
         phase_step_ff    <= PHASE_BITS'(16384);
         floor_coef_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:     window_length_ff <= csr_write_data[LENGTH_BITS-1:0];
            CSR_PHASE_STEP:        phase_step_ff    <= csr_write_data[PHASE_BITS-1:0];
            CSR_FLOOR_COEFFICIENT: floor_coef_ff    <= csr_write_data[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // cosine lookup from quadrant and rounded offset index
   always_comb begin
      quadrant    = phase_ff[PHASE_BITS-1 -: 2];
      scaled      = SCALE_BITS'(phase_ff[PHASE_BITS-3:0]) * SCALE_BITS'(COS_TABLE_DEPTH)
                    + SCALE_BITS'(1 << (PHASE_BITS - 3));
      idx_raw     = scaled[SCALE_BITS-1 -: COS_IDX_BITS];
      idx         = (idx_raw > COS_IDX_BITS'(COS_TABLE_DEPTH)) ?
                    COS_IDX_BITS'(COS_TABLE_DEPTH) : idx_raw;
      table_addr  = quadrant[0] ? (COS_IDX_BITS'(COS_TABLE_DEPTH) - idx) : idx;
      table_value = COS_TABLE[table_addr];
      if (quadrant[1] ^ quadrant[0]) begin
         cos_in = -$signed({1'b0, table_value});
      end else begin
         cos_in = $signed({1'b0, table_value});
      end
   end

   // window end detection and counter advance
   always_comb begin
      pos_next = CMP_BITS'(position_ff) + CMP_BITS'(1);
      len_eff  = (window_length_ff == '0) ? (CMP_BITS'(1) << POSITION_BITS) :
                 CMP_BITS'(window_length_ff);
      last_in  = (pos_next >= len_eff) || (position_ff == '1);
      if (last_in) begin
         position_in = '0;
         phase_in    = '0;
      end else begin
         position_in = pos_next[POSITION_BITS-1:0];
         phase_in    = phase_ff + phase_step_ff;
      end
   end

   // counters and intake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         phase_ff    <= '0;
      end else if (cmd.load_input) begin
         position_ff <= position_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         sample_ff <= req_sample;
         cos_ff    <= cos_in;
         last_ff   <= last_in;
      end
   end

   // weight: a + (1 - a) * (1 - c) / 2, rounded
   always_comb begin
      coef_sat         = (floor_coef_ff > COEF_BITS'(32768)) ? COEF_BITS'(32768) : floor_coef_ff;
      one_minus_a      = WEIGHT_BITS'(32768) - coef_sat;
      one_minus_c_wide = (COS_VALUE_BITS+2)'(32768) - (COS_VALUE_BITS+2)'(cos_ff);
      one_minus_c      = one_minus_c_wide[COS_VALUE_BITS:0];
      span_prod        = (WEIGHT_BITS+COS_VALUE_BITS+2)'(one_minus_a)
                         * (WEIGHT_BITS+COS_VALUE_BITS+2)'(one_minus_c)
                         + (WEIGHT_BITS+COS_VALUE_BITS+2)'(32768);
      weight_in        = coef_sat + WEIGHT_BITS'(span_prod >> 16);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_weight) begin
         weight_ff <= weight_in;
      end
   end

   // product, round to nearest, saturate
   always_comb begin
      product = PROD_BITS'(sample_ff) * $signed({1'b0, weight_ff});
      rounded = product + PROD_BITS'(1 << 14);
      y       = rounded[PROD_BITS-1:15];
      if ((y[Y_BITS-1:SAMPLE_BITS-1] == '0) || (y[Y_BITS-1:SAMPLE_BITS-1] == '1)) begin
         windowed_in = y[SAMPLE_BITS-1:0];
      end else if (y[Y_BITS-1]) begin
         windowed_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         windowed_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_output) begin
         windowed_ff   <= windowed_in;
         window_end_ff <= last_ff;
      end
   end

   assign rsp_windowed_sample = windowed_ff;
   assign rsp_window_end      = window_end_ff;

endmodule

// ===== design/raised_cosine_window_apply.sv =====
// top level of the raised cosine window block: controller plus datapath
// depends on rcwa_pkg, rcwa_controller, rcwa_datapath and the defines header

// Multiplies each incoming sample by a raised-cosine weight
// floor + (1 - floor) * (1 - cos(phase)) / 2, with the cosine read from a
// quarter-wave table and the phase stepped by phase_step per sample; the last
// sample of each window is flagged with window_end and position and phase then
// restart at zero. One sample is in flight at a time and goes from request to
// result through the steps of the controller in order: the table read and
// counter update, the weight multiply and then the sample multiply. A new
// request is taken while the previous result still waits in the output
// register; the controller holds in its last step only while that register
// is full and not being taken. Configuration writes land at once and do not
// touch position or phase.

`include "raised_cosine_window_apply_defines.svh"

module raised_cosine_window_apply
   import rcwa_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]    rsp_windowed_sample,
   output logic                             rsp_window_end,
   input  logic                             csr_write_enable,
   input  logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [CSR_DATA_BITS-1:0]  csr_write_data
);

   ctrl_cmd_type cmd;

   // sequencer
   rcwa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic and registers
   rcwa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_sample          (req_sample),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_windowed_sample (rsp_windowed_sample),
      .rsp_window_end      (rsp_window_end)
   );

   // checks on the sequencing
   `RCWA_ASSERT_NEXT(a_weight_follows_intake, cmd.load_input, cmd.load_weight && !req_ready,
      "weight step did not follow an accepted request")
   `RCWA_ASSERT_NOW(a_no_result_overwrite, cmd.load_output, !rsp_valid || rsp_ready,
      "result register loaded while a result was still pending")
   `RCWA_ASSERT_NOW(a_one_command, 1'b1, $onehot0(cmd),
      "more than one datapath command in a cycle")

endmodule
